// ----- rtl/core/dbcs_text_layout_glyph_addr_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the double-byte text layout block
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DBCS_TEXT_LAYOUT_GLYPH_ADDR_TOP_ASSERT_SVH
`define DBCS_TEXT_LAYOUT_GLYPH_ADDR_TOP_ASSERT_SVH

// same-cycle implication
`define DTLGA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dtlga assertion failed");

// next-cycle implication
`define DTLGA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dtlga assertion failed");

`endif

// ----- rtl/core/dtlga_pkg.sv -----
// ----------------------------------------------------------------------------
// dtlga_pkg
// Shared types, codes and constants of the double-byte text layout block.
// ----------------------------------------------------------------------------
package dtlga_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int POS_W          = 16;
	localparam int OFFS_W         = 24;
	localparam int IDX_W          = 15;
	localparam int GB_W           = 12;
	localparam int ADDR_W         = 5;
	localparam int DATA_W         = 32;

	localparam logic [7:0] GBK_LEAD_MIN  = 8'h81;
	localparam logic [7:0] GBK_TRAIL_MIN = 8'h40;
	localparam logic [7:0] GB_LEAD_MIN   = 8'hA1;
	localparam logic [7:0] GB_TRAIL_MIN  = 8'hA1;
	localparam int         GBK_ROW       = 191;
	localparam int         GB_ROW        = 94;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	localparam logic [1:0] KIND_WIDE   = 2'd0;
	localparam logic [1:0] KIND_NARROW = 2'd1;
	localparam logic [1:0] KIND_SKIP   = 2'd2;
	localparam logic [1:0] KIND_EXTENT = 2'd3;

	typedef enum logic [2:0] {
		REG_ENCODING     = 3'd0,
		REG_FONT_SIZE    = 3'd1,
		REG_X_SPACING    = 3'd2,
		REG_Y_SPACING    = 3'd3,
		REG_ASCII_FIRST  = 3'd4,
		REG_WIDE_PRESENT = 3'd5,
		REG_NARR_PRESENT = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic       encoding;
		logic [6:0] font_size;
		logic [7:0] x_spacing;
		logic [7:0] y_spacing;
		logic [7:0] ascii_first_code;
		logic       wide_font_present;
		logic       narrow_font_present;
	} cfg_t;

	typedef struct packed {
		logic load_byte;
		logic setup_held;
		logic fresh;
		logic mul;
		logic emit_glyph;
		logic emit_extent;
	} dp_cmd_t;

	typedef struct packed {
		logic pending;
		logic pair;
		logic is_zero;
		logic is_plain;
		logic slot_free;
	} dp_stat_t;

endpackage

// ----- rtl/core/dbcs_text_layout_glyph_addr_top.sv -----
// ----------------------------------------------------------------------------
// dbcs_text_layout_glyph_addr_top
// Double-byte text layout: glyph offsets, pen positions and text extent.
// ----------------------------------------------------------------------------
// Flow: a byte taken in idle is decoded, its glyph index and size are multiplied
// out, and the result is loaded to the output once the output slot is free. No
// new byte is taken until the sequencer is back in idle; a held lead that turns
// narrow gives its glyph, then the next byte is decoded afresh for a second one.
// Reset: asynchronous; clears the text state, loads register defaults.
module dbcs_text_layout_glyph_addr_top #(
	parameter int COORD_BITS = dtlga_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dtlga_pkg::ADDR_W-1:0]  paddr,
	input  logic [dtlga_pkg::DATA_W-1:0]  pwdata,
	output logic [dtlga_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          text_valid,
	output logic                          text_stall,
	input  logic [7:0]                    text_byte,
	output logic                          glyph_valid,
	input  logic                          glyph_stall,
	output logic [1:0]                    kind,
	output logic [dtlga_pkg::OFFS_W-1:0]  font_offset,
	output logic [dtlga_pkg::POS_W-1:0]   pos_x,
	output logic [dtlga_pkg::POS_W-1:0]   pos_y,
	output logic [dtlga_pkg::POS_W-1:0]   text_width,
	output logic [dtlga_pkg::POS_W-1:0]   text_height,
	output logic                          last
);

	dtlga_pkg::cfg_t     cfg;
	dtlga_pkg::dp_cmd_t  cmd;
	dtlga_pkg::dp_stat_t stat;

	dtlga_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dtlga_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	dtlga_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.stat        (stat),
		.text_byte   (text_byte),
		.glyph_valid (glyph_valid),
		.glyph_stall (glyph_stall),
		.kind        (kind),
		.font_offset (font_offset),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.text_width  (text_width),
		.text_height (text_height),
		.last        (last)
	);

endmodule

// ----- rtl/core/dtlga_cfg.sv -----
// ----------------------------------------------------------------------------
// dtlga_cfg
// APB register file holding the layout configuration.
// ----------------------------------------------------------------------------
module dtlga_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dtlga_pkg::ADDR_W-1:0] paddr,
	input  logic [dtlga_pkg::DATA_W-1:0] pwdata,
	output logic [dtlga_pkg::DATA_W-1:0] prdata,
	output logic                         pready,
	output dtlga_pkg::cfg_t              cfg
);

	dtlga_pkg::cfg_t      cfg_q;
	dtlga_pkg::reg_idx_t  idx;
	logic                 wr;

	assign idx    = dtlga_pkg::reg_idx_t'(paddr[dtlga_pkg::ADDR_W-1:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.encoding            <= 1'b0;
			cfg_q.font_size           <= 7'd16;
			cfg_q.x_spacing           <= 8'd0;
			cfg_q.y_spacing           <= 8'd0;
			cfg_q.ascii_first_code    <= 8'd0;
			cfg_q.wide_font_present   <= 1'b1;
			cfg_q.narrow_font_present <= 1'b1;
		end else if (wr) begin
			case (idx)
				dtlga_pkg::REG_ENCODING:     cfg_q.encoding            <= pwdata[0];
				dtlga_pkg::REG_FONT_SIZE:    cfg_q.font_size           <= pwdata[6:0];
				dtlga_pkg::REG_X_SPACING:    cfg_q.x_spacing           <= pwdata[7:0];
				dtlga_pkg::REG_Y_SPACING:    cfg_q.y_spacing           <= pwdata[7:0];
				dtlga_pkg::REG_ASCII_FIRST:  cfg_q.ascii_first_code    <= pwdata[7:0];
				dtlga_pkg::REG_WIDE_PRESENT: cfg_q.wide_font_present   <= pwdata[0];
				dtlga_pkg::REG_NARR_PRESENT: cfg_q.narrow_font_present <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			dtlga_pkg::REG_ENCODING:     prdata = 32'(cfg_q.encoding);
			dtlga_pkg::REG_FONT_SIZE:    prdata = 32'(cfg_q.font_size);
			dtlga_pkg::REG_X_SPACING:    prdata = 32'(cfg_q.x_spacing);
			dtlga_pkg::REG_Y_SPACING:    prdata = 32'(cfg_q.y_spacing);
			dtlga_pkg::REG_ASCII_FIRST:  prdata = 32'(cfg_q.ascii_first_code);
			dtlga_pkg::REG_WIDE_PRESENT: prdata = 32'(cfg_q.wide_font_present);
			dtlga_pkg::REG_NARR_PRESENT: prdata = 32'(cfg_q.narrow_font_present);
			default:                     prdata = '0;
		endcase
	end

endmodule

// ----- rtl/core/dtlga_ctrl.sv -----
// ----------------------------------------------------------------------------
// dtlga_ctrl
// Sequencer: accept a byte, decode it, run the offset multiply, load output.
// ----------------------------------------------------------------------------
module dtlga_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 text_valid,
	output logic                 text_stall,
	input  dtlga_pkg::dp_stat_t  stat,
	output dtlga_pkg::dp_cmd_t   cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_FRESH  = 6'b000100,
		S_MUL    = 6'b001000,
		S_EMIT   = 6'b010000,
		S_EXTENT = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   fresh_after_q, fresh_after_d;

	assign text_stall = (state_q != S_IDLE);

	always_comb begin
		state_d       = state_q;
		fresh_after_d = fresh_after_q;
		cmd           = '0;
		case (state_q)
			S_IDLE: begin
				if (text_valid) begin
					cmd.load_byte = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.pending) begin
					cmd.setup_held = 1'b1;
					fresh_after_d  = !stat.pair;
					state_d        = S_MUL;
				end else begin
					cmd.fresh     = 1'b1;
					fresh_after_d = 1'b0;
					if (stat.is_zero)
						state_d = S_EXTENT;
					else if (stat.is_plain)
						state_d = S_MUL;
					else
						state_d = S_IDLE;
				end
			end
			S_FRESH: begin
				cmd.fresh     = 1'b1;
				fresh_after_d = 1'b0;
				if (stat.is_zero)
					state_d = S_EXTENT;
				else if (stat.is_plain)
					state_d = S_MUL;
				else
					state_d = S_IDLE;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (stat.slot_free) begin
					cmd.emit_glyph = 1'b1;
					state_d        = fresh_after_q ? S_FRESH : S_IDLE;
				end
			end
			S_EXTENT: begin
				if (stat.slot_free) begin
					cmd.emit_extent = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			fresh_after_q <= 1'b0;
		end else begin
			state_q       <= state_d;
			fresh_after_q <= fresh_after_d;
		end
	end

endmodule

// ----- rtl/core/dtlga_dp.sv -----
// ----------------------------------------------------------------------------
// dtlga_dp
// Datapath: text state, glyph index and size, offset multiply, pen and extent.
// ----------------------------------------------------------------------------
module dtlga_dp #(
	parameter int COORD_BITS = dtlga_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dtlga_pkg::cfg_t               cfg,
	input  dtlga_pkg::dp_cmd_t            cmd,
	output dtlga_pkg::dp_stat_t           stat,
	input  logic [7:0]                    text_byte,
	output logic                          glyph_valid,
	input  logic                          glyph_stall,
	output logic [1:0]                    kind,
	output logic [dtlga_pkg::OFFS_W-1:0]  font_offset,
	output logic [dtlga_pkg::POS_W-1:0]   pos_x,
	output logic [dtlga_pkg::POS_W-1:0]   pos_y,
	output logic [dtlga_pkg::POS_W-1:0]   text_width,
	output logic [dtlga_pkg::POS_W-1:0]   text_height,
	output logic                          last
);

	localparam int CW  = COORD_BITS;
	localparam int IW  = dtlga_pkg::IDX_W;
	localparam int GW  = dtlga_pkg::GB_W;
	localparam int OW  = dtlga_pkg::OFFS_W;

	logic [7:0]    byte_q, held_q;
	logic          pending_q, skip_lf_q;
	logic [CW-1:0] pen_x_q, pen_y_q, widest_q;
	logic [IW-1:0] idx_q;
	logic [GW-1:0] gbytes_q;
	logic [OW-1:0] offs_q;
	logic [1:0]    gkind_q;
	logic [6:0]    w_q;
	logic          last_q;
	logic          out_valid_q;

	logic          is_skiplf, is_zero, is_lead, is_brk, is_plain;
	logic [7:0]    thr;
	logic          pair;
	logic [7:0]    lead_off_gbk, lead_off_gb, trail_off_gbk, trail_off_gb;
	logic [IW-1:0] widx;
	logic [4:0]    wcols;
	logic [5:0]    ntw;
	logic [3:0]    ncols;
	logic [GW-1:0] gb_wide, gb_narrow;
	logic [7:0]    nb;
	logic          wide_sel;
	logic          setup;
	logic [CW:0]   xsum, ysum;
	logic [CW-1:0] pen_x_adv, pen_y_brk;
	logic          slot_free;

	// byte classes as seen by a fresh byte
	assign thr       = cfg.encoding ? dtlga_pkg::GBK_LEAD_MIN : dtlga_pkg::GB_LEAD_MIN;
	assign is_skiplf = (byte_q == dtlga_pkg::CH_LF) && skip_lf_q;
	assign is_zero   = !is_skiplf && (byte_q == dtlga_pkg::CH_NUL);
	assign is_lead   = !is_skiplf && !is_zero && (byte_q >= thr);
	assign is_brk    = !is_skiplf && !is_zero && !is_lead &&
	                   ((byte_q == dtlga_pkg::CH_LF) || (byte_q == dtlga_pkg::CH_CR));
	assign is_plain  = !is_skiplf && !is_zero && !is_lead && !is_brk;

	// double-byte pairing and index
	assign lead_off_gbk  = held_q - dtlga_pkg::GBK_LEAD_MIN;
	assign lead_off_gb   = held_q - dtlga_pkg::GB_LEAD_MIN;
	assign trail_off_gbk = byte_q - dtlga_pkg::GBK_TRAIL_MIN;
	assign trail_off_gb  = byte_q - dtlga_pkg::GB_TRAIL_MIN;

	always_comb begin
		if (cfg.encoding) begin
			pair = (held_q >= dtlga_pkg::GBK_LEAD_MIN) && (byte_q >= dtlga_pkg::GBK_TRAIL_MIN);
			widx = IW'(lead_off_gbk) * IW'(dtlga_pkg::GBK_ROW) + IW'(trail_off_gbk);
		end else begin
			pair = (held_q >= dtlga_pkg::GB_LEAD_MIN) && (byte_q >= dtlga_pkg::GB_TRAIL_MIN);
			widx = IW'(lead_off_gb) * IW'(dtlga_pkg::GB_ROW) + IW'(trail_off_gb);
		end
	end

	// bytes per glyph: stored columns of eight times rows
	assign wcols     = 5'((8'(cfg.font_size) + 8'd7) >> 3);
	assign ntw       = cfg.font_size[6:1];
	assign ncols     = 4'((7'(ntw) + 7'd7) >> 3);
	assign gb_wide   = GW'(wcols) * GW'(cfg.font_size);
	assign gb_narrow = GW'(ncols) * GW'(cfg.font_size);

	assign setup    = cmd.setup_held || (cmd.fresh && is_plain);
	assign wide_sel = cmd.setup_held && pair;
	assign nb       = cmd.setup_held ? held_q : byte_q;

	// saturating pen updates
	assign xsum      = {1'b0, pen_x_q} + (CW+1)'(w_q) + (CW+1)'(cfg.x_spacing);
	assign pen_x_adv = xsum[CW] ? {CW{1'b1}} : xsum[CW-1:0];
	assign ysum      = {1'b0, pen_y_q} + (CW+1)'(cfg.font_size) + (CW+1)'(cfg.y_spacing);
	assign pen_y_brk = ysum[CW] ? {CW{1'b1}} : ysum[CW-1:0];

	assign slot_free = !out_valid_q || !glyph_stall;

	assign stat.pending   = pending_q;
	assign stat.pair      = pair;
	assign stat.is_zero   = is_zero;
	assign stat.is_plain  = is_plain;
	assign stat.slot_free = slot_free;

	always_ff @(posedge clk) begin
		if (cmd.load_byte)
			byte_q <= text_byte;
		if (setup) begin
			if (wide_sel) begin
				idx_q    <= widx;
				gbytes_q <= gb_wide;
				gkind_q  <= cfg.wide_font_present ? dtlga_pkg::KIND_WIDE
				                                  : dtlga_pkg::KIND_SKIP;
				w_q      <= cfg.font_size;
				last_q   <= 1'b1;
			end else begin
				idx_q    <= IW'(8'(nb - cfg.ascii_first_code));
				gbytes_q <= gb_narrow;
				gkind_q  <= (cfg.narrow_font_present && (nb >= cfg.ascii_first_code))
				            ? dtlga_pkg::KIND_NARROW : dtlga_pkg::KIND_SKIP;
				w_q      <= 7'(ntw);
				last_q   <= cmd.setup_held ? !(is_zero || is_plain) : 1'b1;
			end
		end
		if (cmd.mul)
			offs_q <= OW'(idx_q) * OW'(gbytes_q);
		if (cmd.emit_glyph) begin
			kind        <= gkind_q;
			font_offset <= (gkind_q == dtlga_pkg::KIND_SKIP) ? '0 : offs_q;
			pos_x       <= dtlga_pkg::POS_W'(pen_x_q);
			pos_y       <= dtlga_pkg::POS_W'(pen_y_q);
			text_width  <= '0;
			text_height <= '0;
			last        <= last_q;
		end else if (cmd.emit_extent) begin
			kind        <= dtlga_pkg::KIND_EXTENT;
			font_offset <= '0;
			pos_x       <= '0;
			pos_y       <= '0;
			text_width  <= dtlga_pkg::POS_W'(widest_q);
			text_height <= dtlga_pkg::POS_W'(pen_y_brk);
			last        <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			pending_q   <= 1'b0;
			skip_lf_q   <= 1'b0;
			pen_x_q     <= '0;
			pen_y_q     <= '0;
			widest_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.setup_held) begin
				held_q    <= '0;
				pending_q <= 1'b0;
			end
			if (cmd.fresh) begin
				skip_lf_q <= is_brk && (byte_q == dtlga_pkg::CH_CR);
				if (is_lead) begin
					held_q    <= byte_q;
					pending_q <= 1'b1;
				end
				if (is_brk) begin
					pen_x_q <= '0;
					pen_y_q <= pen_y_brk;
				end
			end
			if (cmd.emit_glyph) begin
				pen_x_q <= pen_x_adv;
				if (pen_x_adv > widest_q)
					widest_q <= pen_x_adv;
			end
			if (cmd.emit_extent) begin
				pen_x_q  <= '0;
				pen_y_q  <= '0;
				widest_q <= '0;
			end
			if (cmd.emit_glyph || cmd.emit_extent)
				out_valid_q <= 1'b1;
			else if (!glyph_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign glyph_valid = out_valid_q;

endmodule

// ----- rtl/core/dtlga_checker.sv -----
// ----------------------------------------------------------------------------
// dtlga_checker
// Port-level checks of the text layout block, bound to the top level.
// ----------------------------------------------------------------------------
`include "dbcs_text_layout_glyph_addr_top_assert.svh"

module dtlga_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          glyph_valid,
	input logic                          glyph_stall,
	input logic [1:0]                    kind,
	input logic [dtlga_pkg::OFFS_W-1:0]  font_offset,
	input logic [dtlga_pkg::POS_W-1:0]   pos_x,
	input logic [dtlga_pkg::POS_W-1:0]   pos_y,
	input logic [dtlga_pkg::POS_W-1:0]   text_width,
	input logic [dtlga_pkg::POS_W-1:0]   text_height,
	input logic                          last
);

	logic is_ext, is_skip;

	assign is_ext  = glyph_valid && (kind == dtlga_pkg::KIND_EXTENT);
	assign is_skip = glyph_valid && (kind == dtlga_pkg::KIND_SKIP);

	// hold a stalled transfer
	`DTLGA_ASSERT_NXT(a_out_hold, glyph_valid && glyph_stall, glyph_valid && $stable(kind) && $stable(font_offset) && $stable(pos_x) && $stable(pos_y) && $stable(last))

	`DTLGA_ASSERT_IMP(a_ext_last, is_ext, last && font_offset == '0 && pos_x == '0 && pos_y == '0)

	`DTLGA_ASSERT_IMP(a_glyph_noext, glyph_valid && !is_ext, text_width == '0 && text_height == '0)

	`DTLGA_ASSERT_IMP(a_skip_offs, is_skip, font_offset == '0)

endmodule

bind dbcs_text_layout_glyph_addr_top dtlga_checker u_dtlga_checker (.*);
